FILE: sv/brl_pkg.sv
`default_nettype none

package brl_pkg;

   // Coordinate width of the endpoint and pixel fields.
   localparam int COORD_W = 12;

   // Request kinds carried in the req_type field.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // One request: a kind code and two endpoints used on load.
   typedef struct packed {
      logic                      req_type;
      logic signed [COORD_W-1:0] x_start;
      logic signed [COORD_W-1:0] y_start;
      logic signed [COORD_W-1:0] x_end;
      logic signed [COORD_W-1:0] y_end;
   } brl_req_type;

   // One result: the emitted pixel and its flags.
   typedef struct packed {
      logic signed [COORD_W-1:0] pixel_x;
      logic signed [COORD_W-1:0] pixel_y;
      logic                      pixel_valid;
      logic                      on_canvas;
      logic                      last_pixel;
   } brl_rsp_type;

endpackage

`default_nettype wire

FILE: sv/bresenham_line_rasterizer_core.sv
`default_nettype none
// Bresenham line rasterizer core.
//
// Requests arrive on the req_ channel (valid/ready). A load request
// (req_type REQ_LOAD) sets up a line from its two endpoints and answers with
// an all-zero result. Each advance request (REQ_ADVANCE) emits the next pixel
// of the line, from the start point up to but not including the far
// endpoint; last_pixel marks the final one. Pixels off the square canvas of
// GRID_SIZE by GRID_SIZE are still emitted, with on_canvas low. An advance
// with no line in progress answers with all fields zero.
//
// Every request produces exactly one result on the rsp_ channel. An accepted
// request sits in the input register; once the result register is free, the
// line setup or pixel step is applied as the result register loads, raising
// rsp_valid. One request is accepted per cycle while results are taken; the
// line state is updated in the same cycle as a request moves into the result
// register, so back-to-back advances run at full rate. When the receiver
// stalls, the result register holds and the input register fills, after which
// req_ready drops. Reset empties both registers and ends any line in progress.
module bresenham_line_rasterizer_core
   import brl_pkg::*;
#(
   parameter int GRID_SIZE = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire brl_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      brl_rsp_type rsp_data
);

   localparam logic [COORD_W:0] GRID_LIMIT = (COORD_W+1)'(GRID_SIZE);

   // Pipeline registers.
   logic        req_valid_ff;
   brl_req_type req_data_ff;
   logic        rsp_valid_ff;
   brl_rsp_type rsp_data_ff;
   logic        fire;

   // Line state.
   logic                      line_active_ff, line_active_in;
   logic signed [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic signed [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic signed [COORD_W-1:0] major_end_ff, major_end_in;
   logic signed [COORD_W+1:0] err_term_ff, err_term_in;
   logic        [COORD_W:0]   delta_major_ff, delta_major_in;
   logic        [COORD_W:0]   delta_minor_ff, delta_minor_in;
   logic                      minor_step_neg_ff, minor_step_neg_in;
   logic                      steep_mode_ff, steep_mode_in;
   brl_rsp_type               rsp_in;

   // Load setup terms.
   logic                      swap_x;
   logic signed [COORD_W-1:0] xa, ya, xb, yb;
   logic signed [COORD_W:0]   dx, dy;
   logic        [COORD_W:0]   ady;
   logic                      dy_neg, shallow;

   // Advance step terms.
   logic                      err_ge;
   logic signed [COORD_W-1:0] minor_cur, minor_next, major_cur;
   logic signed [COORD_W:0]   major_next;
   logic                      line_done;

   // The result stage takes a request when it is empty or being drained.
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         req_data_ff <= req_data;
      end
   end

   // Load setup: order endpoints so x rises, then pick the drawing mode.
   // A steep down-sloping line starts from the other end so y rises.
   always_comb begin
      swap_x  = req_data_ff.x_end < req_data_ff.x_start;
      xa      = swap_x ? req_data_ff.x_end   : req_data_ff.x_start;
      ya      = swap_x ? req_data_ff.y_end   : req_data_ff.y_start;
      xb      = swap_x ? req_data_ff.x_start : req_data_ff.x_end;
      yb      = swap_x ? req_data_ff.y_start : req_data_ff.y_end;
      dx      = (COORD_W+1)'(xb) - (COORD_W+1)'(xa);
      dy      = (COORD_W+1)'(yb) - (COORD_W+1)'(ya);
      dy_neg  = dy[COORD_W];
      ady     = dy_neg ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
      shallow = $unsigned(dx) > ady;
   end

   // Advance step: emit the current pixel, then move one step on the major
   // axis and, when the error term allows, one step on the minor axis.
   always_comb begin
      err_ge     = !err_term_ff[COORD_W+1];
      minor_cur  = steep_mode_ff ? cur_col_ff : cur_row_ff;
      major_cur  = steep_mode_ff ? cur_row_ff : cur_col_ff;
      minor_next = minor_cur;
      if (err_ge) begin
         minor_next = minor_step_neg_ff ? minor_cur - COORD_W'(1) : minor_cur + COORD_W'(1);
      end
      major_next = (COORD_W+1)'(major_cur) + (COORD_W+1)'(1);
      line_done  = major_next >= (COORD_W+1)'(major_end_ff);
   end

   // Next line state and result.
   always_comb begin
      line_active_in    = line_active_ff;
      cur_col_in        = cur_col_ff;
      cur_row_in        = cur_row_ff;
      major_end_in      = major_end_ff;
      err_term_in       = err_term_ff;
      delta_major_in    = delta_major_ff;
      delta_minor_in    = delta_minor_ff;
      minor_step_neg_in = minor_step_neg_ff;
      steep_mode_in     = steep_mode_ff;
      rsp_in            = '0;
      if (req_data_ff.req_type == REQ_LOAD) begin
         minor_step_neg_in = dy_neg;
         steep_mode_in     = !shallow;
         if (shallow) begin
            cur_col_in     = xa;
            cur_row_in     = ya;
            major_end_in   = xb;
            delta_major_in = $unsigned(dx);
            delta_minor_in = ady;
            line_active_in = 1'b1;
         end else begin
            // Steep: y is the major axis and always runs upward.
            cur_col_in     = dy_neg ? xb : xa;
            cur_row_in     = dy_neg ? yb : ya;
            major_end_in   = dy_neg ? ya : yb;
            delta_major_in = ady;
            delta_minor_in = $unsigned(dx);
            line_active_in = ady != '0;
         end
         err_term_in = $signed({1'b0, delta_minor_in}) - $signed({1'b0, delta_major_in});
      end else if (line_active_ff) begin
         rsp_in.pixel_x     = cur_col_ff;
         rsp_in.pixel_y     = cur_row_ff;
         rsp_in.pixel_valid = 1'b1;
         rsp_in.on_canvas   = !cur_col_ff[COORD_W-1] && !cur_row_ff[COORD_W-1]
                              && ({1'b0, cur_col_ff} < GRID_LIMIT)
                              && ({1'b0, cur_row_ff} < GRID_LIMIT);
         err_term_in = err_term_ff
                       - (err_ge ? $signed({1'b0, delta_major_ff}) : '0)
                       + $signed({1'b0, delta_minor_ff});
         if (steep_mode_ff) begin
            cur_col_in = minor_next;
            cur_row_in = major_next[COORD_W-1:0];
         end else begin
            cur_row_in = minor_next;
            cur_col_in = major_next[COORD_W-1:0];
         end
         line_active_in    = !line_done;
         rsp_in.last_pixel = line_done;
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         line_active_ff <= 1'b0;
      end else begin
         if (fire) begin
            rsp_valid_ff   <= 1'b1;
            line_active_ff <= line_active_in;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
      if (fire) begin
         rsp_data_ff       <= rsp_in;
         cur_col_ff        <= cur_col_in;
         cur_row_ff        <= cur_row_in;
         major_end_ff      <= major_end_in;
         err_term_ff       <= err_term_in;
         delta_major_ff    <= delta_major_in;
         delta_minor_ff    <= delta_minor_in;
         minor_step_neg_ff <= minor_step_neg_in;
         steep_mode_ff     <= steep_mode_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/brl_checker.sv
`default_nettype none

module brl_checker
   import brl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire brl_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire brl_rsp_type rsp_data
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A result without a pixel carries no flags and no coordinates.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pixel_valid |->
         !rsp_data.on_canvas && !rsp_data.last_pixel
         && rsp_data.pixel_x == '0 && rsp_data.pixel_y == '0)
      else $error("flags set on an empty result");

   // A pixel on the canvas never has a negative coordinate.
   a_canvas_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.on_canvas |->
         !rsp_data.pixel_x[COORD_W-1] && !rsp_data.pixel_y[COORD_W-1])
      else $error("negative coordinate flagged on canvas");

endmodule

bind bresenham_line_rasterizer_core brl_checker u_brl_checker (.*);

`default_nettype wire
